// File: hdl/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants for the degree-input Taylor cosine block.
// ----------------------------------------------------------------------------
package tcd_pkg;

    // Internal working format: magnitudes with 48 fraction bits
    localparam int          WORK_FRAC = 48;
    localparam logic [63:0] ONE_Q48   = 64'd1 << WORK_FRAC;

    // round(3.141592 / 180 * 2^40); |angle_q8| * PI_DEG_Q40 gives |x| in Q48
    localparam logic [63:0] PI_DEG_Q40 =
        ((64'd3141592 << 40) + 64'd90000000) / 64'd180000000;
    localparam int          PI_DEG_W   = 35;

    localparam int          ANGLE_W    = 18;
    localparam int          VALUE_W    = 32;
    localparam int          NTERMS_W   = 5;
    localparam logic [NTERMS_W-1:0] NTERMS_RESET = 5'd8;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_degrees;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] cosine_value;
        logic                      saturated;
    } t_out_item;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        OP_SQ       = 2'd0,   // xmag * xmag
        OP_X2_RECIP = 2'd1,   // x2 * recip[i]
        OP_TERM_RES = 2'd2    // term * previous product
    } t_op;

    typedef struct packed {
        logic load;       // take a new angle
        t_op  op;
        logic cap_x2;     // capture x^2, seed term and accumulator
        logic acc_one;    // seed accumulator with term 0 (else zero)
        logic cap_term;   // capture next term and accumulate
        logic out_load;   // load the output register
    } t_cmd;

endpackage

// File: hdl/tcd_stream_if.sv
// ----------------------------------------------------------------------------
// tcd_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface tcd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/tcd_mul.sv
// ----------------------------------------------------------------------------
// tcd_mul
// Two-stage 64x64 unsigned multiplier, returns round(a * b / 2^48).
// ----------------------------------------------------------------------------
module tcd_mul (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] w_full;

    // stage 1: four 32x32 partial products
    always_ff @(posedge i_clk) begin
        r_p00 <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
        r_p01 <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
        r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
        r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
    end

    // stage 2: combine, round half up on the dropped bits
    assign w_full = {64'd0, r_p00}
                  + ({64'd0, r_p01} << 32)
                  + ({64'd0, r_p10} << 32)
                  + {r_p11, 64'd0}
                  + (128'd1 << (tcd_pkg::WORK_FRAC - 1));

    always_ff @(posedge i_clk) begin
        o_p <= w_full[tcd_pkg::WORK_FRAC+63:tcd_pkg::WORK_FRAC];
    end
endmodule

// File: hdl/tcd_ctrl.sv
// ----------------------------------------------------------------------------
// tcd_ctrl
// Sequencer: term count register, term counter and the series state machine.
// ----------------------------------------------------------------------------
module tcd_ctrl #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tcd_pkg::NTERMS_W-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_out_free,
    output tcd_pkg::t_cmd                        o_cmd,
    output logic [$clog2(MAX_TERMS+1)-1:0]       o_recip_idx
);
    localparam int CW = $clog2(MAX_TERMS + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SQ     = 10'b0000000010,
        S_SQ_W   = 10'b0000000100,
        S_SQ_CAP = 10'b0000001000,
        S_R      = 10'b0000010000,
        S_R_W    = 10'b0000100000,
        S_R_CAP  = 10'b0001000000,
        S_T_W    = 10'b0010000000,
        S_T_CAP  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [tcd_pkg::NTERMS_W-1:0] r_num_terms;
    logic [CW-1:0]               r_n, n_n;
    logic [CW-1:0]               r_i, n_i;
    logic                        w_clip;

    assign w_clip = ({1'b0, r_num_terms} > 6'(MAX_TERMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= tcd_pkg::NTERMS_RESET;
        end else if (i_cfg_we) begin
            r_num_terms <= i_cfg_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = tcd_pkg::OP_SQ;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_n        = w_clip ? CW'(MAX_TERMS) : CW'(r_num_terms);
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = tcd_pkg::OP_SQ;
                n_state  = S_SQ_W;
            end
            S_SQ_W: begin
                n_state = S_SQ_CAP;
            end
            S_SQ_CAP: begin
                o_cmd.cap_x2  = 1'b1;
                o_cmd.acc_one = (r_n != '0);
                n_i           = CW'(1);
                n_state       = (r_n <= CW'(1)) ? S_OUT : S_R;
            end
            S_R: begin
                o_cmd.op = tcd_pkg::OP_X2_RECIP;
                n_state  = S_R_W;
            end
            S_R_W: begin
                n_state = S_R_CAP;
            end
            S_R_CAP: begin
                // product now holds r_i; chain it straight into the term multiply
                o_cmd.op = tcd_pkg::OP_TERM_RES;
                n_state  = S_T_W;
            end
            S_T_W: begin
                n_state = S_T_CAP;
            end
            S_T_CAP: begin
                o_cmd.cap_term = 1'b1;
                if ((r_i + CW'(1)) == r_n) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_R;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_recip_idx = r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SQ))
        else $error("accepted transaction did not start the series");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R) |-> (r_i != '0 && r_i < r_n))
        else $error("term index out of range");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_out_free)
        else $error("output register loaded while occupied");
endmodule

// File: hdl/tcd_dp.sv
// ----------------------------------------------------------------------------
// tcd_dp
// Datapath: radian conversion, series term recurrence, accumulator and the
// rounding/saturating output register.
// ----------------------------------------------------------------------------
module tcd_dp #(
    parameter int MAX_TERMS     = 16,
    parameter int FRACTION_BITS = 23
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tcd_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_TERMS+1)-1:0]         i_recip_idx,
    input  logic signed [tcd_pkg::ANGLE_W-1:0]     i_angle,
    output logic                                   o_out_free,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output tcd_pkg::t_out_item                     o_out_data
);
    localparam int          SHIFT = tcd_pkg::WORK_FRAC - FRACTION_BITS;
    localparam logic [63:0] RND   = 64'd1 << (SHIFT - 1);
    localparam int          XM_W  = tcd_pkg::ANGLE_W + tcd_pkg::PI_DEG_W;

    logic [63:0] r_xmag, r_x2, r_term, r_acc;
    logic        r_tneg;
    logic        r_out_valid;
    tcd_pkg::t_out_item r_out;

    logic [tcd_pkg::ANGLE_W-1:0] w_amag;
    logic [XM_W-1:0]             w_xmag;
    logic [63:0]                 w_a, w_b, w_p;
    logic [63:0]                 w_recip [0:MAX_TERMS];

    // reciprocal table round(2^48 / ((2i-1)(2i))), entry 0 unused
    for (genvar gi = 0; gi <= MAX_TERMS; gi++) begin : g_recip
        if (gi == 0) begin : g_zero
            assign w_recip[gi] = '0;
        end else begin : g_val
            localparam logic [63:0] K     = 64'((2 * gi - 1) * (2 * gi));
            localparam logic [63:0] RECIP = (tcd_pkg::ONE_Q48 + K / 2) / K;
            assign w_recip[gi] = RECIP;
        end
    end

    assign w_amag = i_angle[tcd_pkg::ANGLE_W-1] ? tcd_pkg::ANGLE_W'(-i_angle)
                                                : tcd_pkg::ANGLE_W'(i_angle);
    assign w_xmag = XM_W'(w_amag) * XM_W'(tcd_pkg::PI_DEG_Q40[tcd_pkg::PI_DEG_W-1:0]);

    always_comb begin
        case (i_cmd.op)
            tcd_pkg::OP_SQ: begin
                w_a = r_xmag;
                w_b = r_xmag;
            end
            tcd_pkg::OP_X2_RECIP: begin
                w_a = r_x2;
                w_b = w_recip[i_recip_idx];
            end
            tcd_pkg::OP_TERM_RES: begin
                w_a = r_term;
                w_b = w_p;
            end
            default: begin
                w_a = r_xmag;
                w_b = r_xmag;
            end
        endcase
    end

    tcd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xmag <= 64'(w_xmag);
        end
        if (i_cmd.cap_x2) begin
            r_x2   <= w_p;
            r_term <= tcd_pkg::ONE_Q48;
            r_tneg <= 1'b0;
            r_acc  <= i_cmd.acc_one ? tcd_pkg::ONE_Q48 : 64'd0;
        end else if (i_cmd.cap_term) begin
            // sign flips every term; the sign held before the flip decides add or subtract
            r_term <= w_p;
            r_tneg <= ~r_tneg;
            r_acc  <= r_tneg ? (r_acc + w_p) : (r_acc - w_p);
        end
    end

    // output scaling: round magnitude to FRACTION_BITS, clip to 32 bits
    logic        w_neg, w_sat_pos, w_sat_neg;
    logic [63:0] w_mag, w_m, w_m_clip;
    logic [31:0] w_val;

    assign w_neg     = r_acc[63];
    assign w_mag     = w_neg ? (64'd0 - r_acc) : r_acc;
    assign w_m       = (w_mag + RND) >> SHIFT;
    assign w_sat_pos = !w_neg && (w_m > 64'h0000_0000_7FFF_FFFF);
    assign w_sat_neg =  w_neg && (w_m > 64'h0000_0000_8000_0000);
    assign w_m_clip  = w_sat_pos ? 64'h0000_0000_7FFF_FFFF :
                       w_sat_neg ? 64'h0000_0000_8000_0000 : w_m;
    assign w_val     = w_neg ? (32'd0 - w_m_clip[31:0]) : w_m_clip[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cosine_value <= w_val;
            r_out.saturated    <= w_sat_pos | w_sat_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.saturated) |->
            (r_out.cosine_value == 32'sh7FFF_FFFF ||
             r_out.cosine_value == 32'sh8000_0000))
        else $error("saturated flag with a non-extreme value");
endmodule

// File: hdl/taylor_cosine_degrees_top.sv
// N = terms summed (num_terms clipped to MAX_TERMS); N of 0 or 1 skips the term loop.
// Each term is two passes through the shared two-stage multiplier plus an accumulate
//   step. A new item is taken only in idle, after the last result is loaded for output.
// The output register lets the next item start while a result is waiting.
// Reset (synchronous, active low) idles the sequencer, empties the output, sets num_terms to 8.
// ----------------------------------------------------------------------------
// taylor_cosine_degrees_top
// Cosine of an angle in degrees by a truncated Maclaurin series.
// ----------------------------------------------------------------------------
module taylor_cosine_degrees_top #(
    parameter int MAX_TERMS     = 16,
    parameter int FRACTION_BITS = 23
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcd_pkg::NTERMS_W-1:0]  i_cfg_data,
    tcd_stream_if.sink                    i_in_ch,
    tcd_stream_if.source                  o_out_ch
);
    tcd_pkg::t_cmd                    w_cmd;
    logic [$clog2(MAX_TERMS+1)-1:0]   w_recip_idx;
    logic                             w_out_free;
    tcd_pkg::t_in_item                w_in_item;

    assign w_in_item = i_in_ch.data;

    tcd_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_out_free  (w_out_free),
        .o_cmd       (w_cmd),
        .o_recip_idx (w_recip_idx)
    );

    tcd_dp #(
        .MAX_TERMS     (MAX_TERMS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_recip_idx (w_recip_idx),
        .i_angle     (w_in_item.angle_degrees),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_out_data  (o_out_ch.data)
    );
endmodule
